@@ sv/ttdt_pkg.sv @@
// Shared types and constants of the tickless tick deadline timer.
// Used by the controller, the datapath and the top level.
`default_nettype none

package ttdt_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd19200;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PARK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNPARK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ARM    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd4;

  // Register index of tick_period
  localparam logic REG_TICK_PERIOD = 1'b0;

  typedef struct packed {
    logic load;       // capture the input beat
    logic div_start;  // launch the elapsed-period division
    logic commit;     // update state and load the output register
  } ttdt_cmd_t;

  typedef struct packed {
    logic in_unpark;  // input beat is an unpark event
    logic div_done;   // last divider step at this edge
  } ttdt_sts_t;

endpackage

`default_nettype wire

@@ sv/tickless_tick_deadline_timer.sv @@
// Top level of the tickless tick deadline timer: stream ports, APB register port.
// Instantiates ttdt_ctrl and ttdt_dp; uses ttdt_pkg.
//
// Usage: each input beat carries an event kind (tuser) and the counter value
// now plus a requested park deadline (tdata). Every event yields exactly one
// output beat with the comparator deadline, enable, missed tick count and
// parked flag after the event. tick_period is written over APB at address 0;
// the user must write it only while the block is idle; the block does not enforce it.
// Flow: tick, park, arm, stop and undefined kinds go from the accepting edge to
// the commit state, which loads the output register and raises output valid;
// unpark first waits in the divide state for the serial 64-bit by 32-bit divider
// that computes the elapsed periods (one quotient bit per cycle, 64 steps). One
// event is in work at a time; a new beat is accepted only once it has committed.
// A finished result sits in the output register; the next beat is accepted
// meanwhile, but its result waits until the receiver takes the previous one.
// Reset clears the timer state, sets tick_period to 19200 and empties the
// output register.
`default_nettype none

module tickless_tick_deadline_timer
  import ttdt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [127:0]        s_axis_tdata,  // now[63:0], park_deadline[127:64]
  input  wire logic [KIND_W-1:0]   s_axis_tuser,  // kind[2:0]
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // compare_value[63:0], comparator_on[64], missed_ticks[96:65], is_parked[97], zero[103:98]
  output logic [103:0]             m_axis_tdata,
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  ttdt_cmd_t           cmd;
  ttdt_sts_t           sts;
  logic                cfg_we;
  logic [PERIOD_W-1:0] tick_period;
  logic [TIME_W-1:0]   compare_value;
  logic                comparator_on;
  logic [COUNT_W-1:0]  missed_ticks;
  logic                is_parked;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_TICK_PERIOD);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? tick_period : '0;

  ttdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ttdt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_kind_i          (s_axis_tuser),
    .in_now_i           (s_axis_tdata[63:0]),
    .in_park_deadline_i (s_axis_tdata[127:64]),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (pwdata),
    .tick_period_o      (tick_period),
    .compare_value_o    (compare_value),
    .comparator_on_o    (comparator_on),
    .missed_ticks_o     (missed_ticks),
    .is_parked_o        (is_parked)
  );

  assign m_axis_tdata = {6'b0, is_parked, missed_ticks, comparator_on, compare_value};

  // Output register is only overwritten once the previous beat is gone.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result committed over a pending output beat");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  a_div_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> !s_axis_tready)
    else $error("divider finished while accepting input");

  a_start_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_UNPARK))
    else $error("division launched without an unpark beat");

endmodule

`default_nettype wire

@@ sv/ttdt_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Uses ttdt_pkg for widths. A zero divisor yields an all-ones quotient.
`default_nettype none

module ttdt_div
  import ttdt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [TIME_W-1:0]   dividend_i,
  input  wire logic [PERIOD_W-1:0] divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [TIME_W-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(TIME_W);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0]   dvd_q, dvd_d;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;
  logic                qbit;

  always_comb begin
    trial = {rem_q, dvd_q[TIME_W-1]};
    diff  = trial - {1'b0, divisor_i};
    qbit  = (trial >= {1'b0, divisor_i});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(TIME_W - 1);
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = qbit ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      dvd_d = {dvd_q[TIME_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

@@ sv/ttdt_ctrl.sv @@
// Controller state machine of the tick deadline timer.
// Uses ttdt_pkg for the command and status structs; drives the stream handshakes.
`default_nettype none

module ttdt_ctrl
  import ttdt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire ttdt_sts_t  sts_i,
  output ttdt_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_unpark) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIVIDE;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ sv/ttdt_dp.sv @@
// Datapath of the tick deadline timer: event capture, timer state, output register.
// Uses ttdt_pkg and instantiates ttdt_div for the elapsed-period count.
`default_nettype none

module ttdt_dp
  import ttdt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ttdt_cmd_t           cmd_i,
  output ttdt_sts_t                sts_o,
  input  wire logic [KIND_W-1:0]   in_kind_i,
  input  wire logic [TIME_W-1:0]   in_now_i,
  input  wire logic [TIME_W-1:0]   in_park_deadline_i,
  input  wire logic                cfg_we_i,
  input  wire logic [PERIOD_W-1:0] cfg_wdata_i,
  output logic [PERIOD_W-1:0]      tick_period_o,
  output logic [TIME_W-1:0]        compare_value_o,
  output logic                     comparator_on_o,
  output logic [COUNT_W-1:0]       missed_ticks_o,
  output logic                     is_parked_o
);

  logic [KIND_W-1:0]   kind_q;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   req_q;

  logic [PERIOD_W-1:0] period_q;
  logic [TIME_W-1:0]   deadline_q, deadline_d;
  logic                parked_q, parked_d;
  logic [TIME_W-1:0]   park_start_q, park_start_d;
  logic [COUNT_W-1:0]  serviced_q, serviced_d;
  logic                enabled_q, enabled_d;
  logic [COUNT_W-1:0]  missed_d;

  logic [TIME_W-1:0]   out_cmp_q;
  logic                out_on_q;
  logic [COUNT_W-1:0]  out_missed_q;
  logic                out_parked_q;

  logic [TIME_W-1:0]   per64;
  logic [TIME_W-1:0]   now_per;
  logic [TIME_W-1:0]   adv;
  logic [TIME_W-1:0]   quotient;
  logic [COUNT_W-1:0]  elapsed;
  logic                div_busy;
  logic                div_done;

  ttdt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (in_now_i - park_start_q),
    .divisor_i  (period_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign sts_o.in_unpark = (in_kind_i == KIND_UNPARK);
  assign sts_o.div_done  = div_done && div_busy;

  assign per64   = {{(TIME_W-PERIOD_W){1'b0}}, period_q};
  assign now_per = now_q + per64;
  assign adv     = deadline_q + per64;
  assign elapsed = quotient[COUNT_W-1:0];

  always_comb begin
    deadline_d   = deadline_q;
    parked_d     = parked_q;
    park_start_d = park_start_q;
    serviced_d   = serviced_q;
    enabled_d    = enabled_q;
    missed_d     = '0;
    case (kind_q)
      KIND_TICK: begin
        if (parked_q) begin
          serviced_d = serviced_q + 1'b1;
          deadline_d = now_per;
        end else begin
          deadline_d = (adv <= now_q) ? now_per : adv;
        end
      end
      KIND_PARK: begin
        deadline_d   = (req_q < now_per) ? now_per : req_q;
        park_start_d = now_q;
        serviced_d   = '0;
        parked_d     = 1'b1;
      end
      KIND_UNPARK: begin
        parked_d   = 1'b0;
        missed_d   = (elapsed > serviced_q) ? (elapsed - serviced_q) : '0;
        deadline_d = now_per;
      end
      KIND_ARM: begin
        parked_d   = 1'b0;
        deadline_d = now_per;
        enabled_d  = 1'b1;
      end
      KIND_STOP: begin
        enabled_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PERIOD_RESET;
      deadline_q   <= '0;
      parked_q     <= 1'b0;
      park_start_q <= '0;
      serviced_q   <= '0;
      enabled_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        deadline_q   <= deadline_d;
        parked_q     <= parked_d;
        park_start_q <= park_start_d;
        serviced_q   <= serviced_d;
        enabled_q    <= enabled_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      now_q  <= in_now_i;
      req_q  <= in_park_deadline_i;
    end
    if (cmd_i.commit) begin
      out_cmp_q    <= deadline_d;
      out_on_q     <= enabled_d;
      out_missed_q <= missed_d;
      out_parked_q <= parked_d;
    end
  end

  assign tick_period_o   = period_q;
  assign compare_value_o = out_cmp_q;
  assign comparator_on_o = out_on_q;
  assign missed_ticks_o  = out_missed_q;
  assign is_parked_o     = out_parked_q;

endmodule

`default_nettype wire
